// ----- hdl/i2ctrf_pkg.sv -----
// ----------------------------------------------------------------------------
// i2ctrf_pkg
// shared types and constants of the i2c target register file
// ----------------------------------------------------------------------------
`default_nettype none

package i2ctrf_pkg;

  localparam int unsigned REG_BYTES  = 32;
  localparam int unsigned IDX_W      = $clog2(REG_BYTES);
  localparam int unsigned NUM_BANKS  = 8;
  localparam int unsigned BANK_W     = $clog2(NUM_BANKS);
  localparam int unsigned BANK_DEPTH = REG_BYTES / NUM_BANKS;
  localparam int unsigned ROW_W      = $clog2(BANK_DEPTH);
  localparam int unsigned ADDR_W     = 7;

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_OVERFLOW = 2'd1,
    ACT_LWRITE   = 2'd2,
    ACT_LREAD    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    PH_ADDR       = 3'd0,
    PH_POINTER    = 3'd1,
    PH_DATA_IN    = 3'd2,
    PH_DATA_ACKED = 3'd3,
    PH_SENDING    = 3'd4,
    PH_AWAIT_ACK  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [6:0]  pad;
    logic [1:0]  local_size;
    logic [63:0] local_data;
    logic [4:0]  local_addr;
    logic        stop_seen;
    logic        sda_level;
    logic [7:0]  shifted_byte;
  } in_data_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic        active;
    logic [2:0]  bus_state;
    logic [63:0] local_read_data;
    logic [7:0]  tx_byte;
    logic        slave_ack;
  } out_data_t;

endpackage

`default_nettype wire

// ----- hdl/i2ctrf_ram.sv -----
// ----------------------------------------------------------------------------
// i2ctrf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/i2c_target_register_file.sv -----
// ----------------------------------------------------------------------------
// i2c_target_register_file
// byte level i2c target with an auto-incrementing 32 byte register file
// ----------------------------------------------------------------------------
// result: registered, presented on the master side in the cycle after the event is accepted
// throughput: one event per cycle while the master side is not stalled, set by the
//   single registered read of the eight byte-wide bank rams
// reset: asynchronous, active low; clears phase, pointer, flags, own address
//   and the per-byte valid bits, so unwritten bytes read as zero at once
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_target_register_file (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // shifted_byte, sda_level, stop_seen, local_addr, local_data, local_size
  input  wire logic [87:0] s_axis_tdata,
  // action
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // slave_ack, tx_byte, local_read_data, bus_state, active
  output logic [79:0]      m_axis_tdata,
  // tx_load
  output logic             m_axis_tuser
);

  localparam int unsigned NB = i2ctrf_pkg::NUM_BANKS;

  i2ctrf_pkg::in_data_t  in_d;
  i2ctrf_pkg::out_data_t out_d;
  i2ctrf_pkg::action_e   action;
  i2ctrf_pkg::phase_e    phase_q, phase_d;

  logic                              accept;
  logic [i2ctrf_pkg::ADDR_W-1:0]     own_q;
  logic [i2ctrf_pkg::IDX_W-1:0]      ptr_q, ptr_d;
  logic                              ackph_q, ackph_d;
  logic                              en_q, en_d;
  logic [i2ctrf_pkg::REG_BYTES-1:0]  valid_q, valid_d;

  logic                              ack_out, load_out, bus_wr;
  logic                              s1_valid_q;
  logic                              s1_ack_q, s1_load_q, s1_lread_q;
  logic [i2ctrf_pkg::BANK_W-1:0]     s1_lo_q, s1_txbank_q, s1_last_q;
  logic [NB-1:0]                     rvld_q, rvld_d;
  logic [i2ctrf_pkg::BANK_W-1:0]     last_k;

  logic                              we   [NB];
  logic [i2ctrf_pkg::ROW_W-1:0]      waddr[NB];
  logic [7:0]                        wdata[NB];
  logic [i2ctrf_pkg::ROW_W-1:0]      raddr[NB];
  logic [7:0]                        rdata[NB];

  assign in_d   = i2ctrf_pkg::in_data_t'(s_axis_tdata);
  assign action = i2ctrf_pkg::action_e'(s_axis_tuser);

  assign s_axis_tready = !s1_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_k        = i2ctrf_pkg::BANK_W'((32'd1 << in_d.local_size) - 32'd1);

  // next state
  always_comb begin
    phase_d = phase_q;
    ptr_d   = ptr_q;
    ackph_d = ackph_q;
    en_d    = en_q;
    if (accept) begin
      case (action)
        i2ctrf_pkg::ACT_START: begin
          if (phase_q == i2ctrf_pkg::PH_DATA_IN) begin
            phase_d = i2ctrf_pkg::PH_ADDR;
          end else begin
            en_d = 1'b1;
          end
        end
        i2ctrf_pkg::ACT_OVERFLOW: begin
          if (en_q && ackph_q) begin
            if (phase_q == i2ctrf_pkg::PH_AWAIT_ACK) begin
              if (!in_d.sda_level) begin
                phase_d = i2ctrf_pkg::PH_SENDING;
                ptr_d   = ptr_q + i2ctrf_pkg::IDX_W'(1);
              end else begin
                phase_d = i2ctrf_pkg::PH_ADDR;
                ptr_d   = '0;
                en_d    = 1'b0;
              end
            end else if (phase_q == i2ctrf_pkg::PH_DATA_ACKED) begin
              if (in_d.stop_seen) begin
                phase_d = i2ctrf_pkg::PH_ADDR;
                ptr_d   = '0;
                en_d    = 1'b0;
              end else begin
                phase_d = i2ctrf_pkg::PH_DATA_IN;
                ptr_d   = ptr_q + i2ctrf_pkg::IDX_W'(1);
              end
            end
            ackph_d = 1'b0;
          end else if (en_q) begin
            case (phase_q)
              i2ctrf_pkg::PH_ADDR: begin
                if (in_d.shifted_byte[7:1] == own_q) begin
                  phase_d = in_d.shifted_byte[0] ? i2ctrf_pkg::PH_SENDING
                                                 : i2ctrf_pkg::PH_POINTER;
                  ackph_d = 1'b1;
                end
              end
              i2ctrf_pkg::PH_POINTER: begin
                ptr_d   = in_d.shifted_byte[i2ctrf_pkg::IDX_W-1:0];
                phase_d = i2ctrf_pkg::PH_DATA_IN;
                ackph_d = 1'b1;
              end
              i2ctrf_pkg::PH_DATA_IN: begin
                phase_d = i2ctrf_pkg::PH_DATA_ACKED;
                ackph_d = 1'b1;
              end
              i2ctrf_pkg::PH_SENDING: begin
                phase_d = i2ctrf_pkg::PH_AWAIT_ACK;
                ackph_d = 1'b1;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // outputs of the event decode
  always_comb begin
    ack_out  = 1'b0;
    load_out = 1'b0;
    bus_wr   = 1'b0;
    if (accept && action == i2ctrf_pkg::ACT_OVERFLOW && en_q) begin
      if (ackph_q) begin
        load_out = (phase_q == i2ctrf_pkg::PH_SENDING) ||
                   (phase_q == i2ctrf_pkg::PH_AWAIT_ACK && !in_d.sda_level);
      end else begin
        case (phase_q)
          i2ctrf_pkg::PH_ADDR:    ack_out = (in_d.shifted_byte[7:1] == own_q);
          i2ctrf_pkg::PH_POINTER: ack_out = 1'b1;
          i2ctrf_pkg::PH_DATA_IN: begin
            ack_out = 1'b1;
            bus_wr  = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // bank addressing: byte index i lives in bank i mod 8, row i div 8
  always_comb begin
    logic [i2ctrf_pkg::BANK_W-1:0] k;
    logic [i2ctrf_pkg::BANK_W-1:0] sel;
    logic [i2ctrf_pkg::IDX_W-1:0]  idx;
    logic [63:0]                   shifted;
    valid_d = valid_q;
    for (int b = 0; b < NB; b++) begin
      k       = i2ctrf_pkg::BANK_W'(b) - in_d.local_addr[i2ctrf_pkg::BANK_W-1:0];
      idx     = in_d.local_addr + i2ctrf_pkg::IDX_W'(k);
      sel     = last_k - k;
      shifted = in_d.local_data >> {sel, 3'b000};
      if (accept && action == i2ctrf_pkg::ACT_LWRITE) begin
        we[b]    = (k <= last_k);
        waddr[b] = idx[i2ctrf_pkg::IDX_W-1:i2ctrf_pkg::BANK_W];
        wdata[b] = shifted[7:0];
      end else begin
        we[b]    = bus_wr && (ptr_q[i2ctrf_pkg::BANK_W-1:0] == i2ctrf_pkg::BANK_W'(b));
        waddr[b] = ptr_q[i2ctrf_pkg::IDX_W-1:i2ctrf_pkg::BANK_W];
        wdata[b] = in_d.shifted_byte;
      end
      if (action == i2ctrf_pkg::ACT_LREAD) begin
        raddr[b] = idx[i2ctrf_pkg::IDX_W-1:i2ctrf_pkg::BANK_W];
      end else begin
        raddr[b] = ptr_d[i2ctrf_pkg::IDX_W-1:i2ctrf_pkg::BANK_W];
      end
      rvld_d[b] = valid_q[{raddr[b], i2ctrf_pkg::BANK_W'(b)}];
      if (we[b]) begin
        valid_d[{waddr[b], i2ctrf_pkg::BANK_W'(b)}] = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_bank
    i2ctrf_ram #(
      .WIDTH(8),
      .DEPTH(i2ctrf_pkg::BANK_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[g]),
      .waddr_i(waddr[g]),
      .wdata_i(wdata[g]),
      .re_i   (accept),
      .raddr_i(raddr[g]),
      .rdata_o(rdata[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q      <= '0;
      phase_q    <= i2ctrf_pkg::PH_ADDR;
      ptr_q      <= '0;
      ackph_q    <= 1'b0;
      en_q       <= 1'b0;
      valid_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      ackph_q <= ackph_d;
      en_q    <= en_d;
      valid_q <= valid_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ack_q    <= ack_out;
      s1_load_q   <= load_out;
      s1_lread_q  <= (action == i2ctrf_pkg::ACT_LREAD);
      s1_lo_q     <= in_d.local_addr[i2ctrf_pkg::BANK_W-1:0];
      s1_last_q   <= last_k;
      s1_txbank_q <= ptr_d[i2ctrf_pkg::BANK_W-1:0];
      rvld_q      <= rvld_d;
    end
  end

  // result assembly, most significant byte at the lowest index
  always_comb begin
    logic [i2ctrf_pkg::BANK_W-1:0] bank;
    logic [i2ctrf_pkg::BANK_W-1:0] sel;
    logic [7:0]                    rbyte;
    logic [63:0]                   rd;
    rd = '0;
    for (int k = 0; k < NB; k++) begin
      bank  = s1_lo_q + i2ctrf_pkg::BANK_W'(k);
      sel   = s1_last_q - i2ctrf_pkg::BANK_W'(k);
      rbyte = rdata[bank] & {8{rvld_q[bank]}};
      if (s1_lread_q && (i2ctrf_pkg::BANK_W'(k) <= s1_last_q)) begin
        rd = rd | (64'(rbyte) << {sel, 3'b000});
      end
    end
    out_d.pad             = '0;
    out_d.active          = en_q;
    out_d.bus_state       = phase_q;
    out_d.local_read_data = rd;
    out_d.tx_byte         = s1_load_q ? (rdata[s1_txbank_q] & {8{rvld_q[s1_txbank_q]}})
                                      : 8'h00;
    out_d.slave_ack       = s1_ack_q;
  end

  assign m_axis_tvalid = s1_valid_q;
  assign m_axis_tdata  = out_d;
  assign m_axis_tuser  = s1_load_q;

  a_ackph_needs_en : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ackph_q |-> en_q)
    else $error("ack phase pending while target disabled");

  a_ack_load_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_d.slave_ack && m_axis_tuser))
    else $error("ack and transmit load in one transaction");

  a_load_sending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (phase_q == i2ctrf_pkg::PH_SENDING))
    else $error("transmit load outside sending phase");

  a_ack_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_d.slave_ack) |->
      (phase_q == i2ctrf_pkg::PH_POINTER || phase_q == i2ctrf_pkg::PH_DATA_IN ||
       phase_q == i2ctrf_pkg::PH_DATA_ACKED || phase_q == i2ctrf_pkg::PH_SENDING))
    else $error("ack given from an unexpected phase");

endmodule

`default_nettype wire
